>>> hdl/sft_pkg.sv
// Shared types and constants for the sorted frame table.
`timescale 1ns / 1ps

package sft_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int FRAME_W     = 32;
    localparam int INDEX_W     = 10;
    localparam int POS_W       = 11;
    localparam int STATUS_W    = 2;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic                frame_used;
        logic                next_valid;
        logic [FRAME_W-1:0]  next_frame;
        logic [FRAME_W-1:0]  frame_value;
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    entry_count;
    } result_t;

endpackage

>>> hdl/sft_mem.sv
// Frame store: one write port and one registered read port.
`timescale 1ns / 1ps

module sft_mem #(
    parameter int TABLE_DEPTH = sft_pkg::TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [sft_pkg::FRAME_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [sft_pkg::FRAME_W-1:0] wr_data
);

    logic [sft_pkg::FRAME_W-1:0] store [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= store[rd_addr];
        end
    end

endmodule

>>> hdl/sft_ctrl.sv
// Sequencer: clear, binary search, shift-up insert, query and indexed read over the frame store.
`timescale 1ns / 1ps

module sft_ctrl #(
    parameter int TABLE_DEPTH = sft_pkg::TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH),
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   in_action,
    input  logic [sft_pkg::FRAME_W-1:0]  in_frame,
    input  logic [sft_pkg::INDEX_W-1:0]  in_index,
    output logic                         res_valid,
    input  logic                         res_ack,
    output sft_pkg::result_t             res,
    output logic                         mem_rd_en,
    output logic [AW-1:0]                mem_rd_addr,
    input  logic [sft_pkg::FRAME_W-1:0]  mem_rd_data,
    output logic                         mem_wr_en,
    output logic [AW-1:0]                mem_wr_addr,
    output logic [sft_pkg::FRAME_W-1:0]  mem_wr_data
);

    localparam int IW = (CW > sft_pkg::INDEX_W) ? CW : sft_pkg::INDEX_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT,
        S_PUT_KEY,
        S_READ_WAIT,
        S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    sft_pkg::action_t            action_reg, action_next;
    logic [sft_pkg::FRAME_W-1:0] key_reg, key_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               lo_reg, lo_next;
    logic [CW-1:0]               hi_reg, hi_next;
    logic [CW-1:0]               mid_reg, mid_next;
    logic                        upper_reg, upper_next;
    logic                        matched_reg, matched_next;
    logic                        hi_moved_reg, hi_moved_next;
    logic [sft_pkg::FRAME_W-1:0] cand_reg, cand_next;
    logic [CW-1:0]               pos_reg, pos_next;
    logic [AW-1:0]               rd_ptr_reg, rd_ptr_next;
    logic                        rd_active_reg, rd_active_next;
    logic                        pend_reg, pend_next;
    logic [AW-1:0]               pend_addr_reg, pend_addr_next;
    sft_pkg::result_t            res_reg, res_next;

    logic [CW:0]                 mid_sum;

    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        upper_next     = upper_reg;
        matched_next   = matched_reg;
        hi_moved_next  = hi_moved_reg;
        cand_next      = cand_reg;
        pos_next       = pos_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_active_next = rd_active_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        res_next       = res_reg;
        mid_sum        = '0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = mem_rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next   = sft_pkg::action_t'(in_action);
                    key_next      = in_frame;
                    lo_next       = '0;
                    hi_next       = count_reg;
                    mid_next      = count_reg >> 1;
                    upper_next    = 1'b0;
                    matched_next  = 1'b0;
                    hi_moved_next = 1'b0;
                    cand_next     = '0;
                    res_next      = '0;
                    case (sft_pkg::action_t'(in_action))
                        sft_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        sft_pkg::ACT_INSERT, sft_pkg::ACT_QUERY:
                        begin
                            state_next = S_SRCH_RD;
                        end
                        sft_pkg::ACT_READ:
                        begin
                            if (IW'(in_index) < IW'(count_reg))
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = AW'(in_index);
                                state_next  = S_READ_WAIT;
                            end
                            else
                            begin
                                res_next.status = sft_pkg::STATUS_RANGE;
                                state_next      = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(mid_reg);
                    state_next  = S_SRCH_CMP;
                end
                else if (action_reg == sft_pkg::ACT_INSERT)
                begin
                    pos_next          = mid_reg;
                    res_next.position = sft_pkg::POS_W'(mid_reg);
                    if (count_reg == DEPTH_C)
                    begin
                        res_next.status = sft_pkg::STATUS_FULL;
                        state_next      = S_DONE;
                    end
                    else if (count_reg > mid_reg)
                    begin
                        rd_ptr_next    = AW'(count_reg - 1'b1);
                        rd_active_next = 1'b1;
                        pend_next      = 1'b0;
                        state_next     = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_PUT_KEY;
                    end
                end
                else if (!upper_reg)
                begin
                    res_next.position   = sft_pkg::POS_W'(mid_reg);
                    res_next.frame_used = matched_reg;
                    upper_next          = 1'b1;
                    lo_next             = '0;
                    hi_next             = count_reg;
                    mid_next            = count_reg >> 1;
                end
                else
                begin
                    res_next.next_valid = hi_moved_reg;
                    res_next.next_frame = cand_reg;
                    state_next          = S_DONE;
                end
            end

            S_SRCH_CMP:
            begin
                state_next = S_SRCH_RD;
                if (!upper_reg && mem_rd_data == key_reg)
                begin
                    matched_next = 1'b1;
                    lo_next      = mid_reg;
                    hi_next      = mid_reg;
                end
                else
                begin
                    if (mem_rd_data > key_reg)
                    begin
                        hi_next = mid_reg;
                        if (upper_reg)
                        begin
                            cand_next     = mem_rd_data;
                            hi_moved_next = 1'b1;
                        end
                    end
                    else
                    begin
                        lo_next = mid_reg + 1'b1;
                    end
                    mid_sum  = {1'b0, lo_next} + {1'b0, hi_next};
                    mid_next = mid_sum[CW:1];
                end
            end

            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pend_addr_reg;
                    mem_wr_data = mem_rd_data;
                end
                if (rd_active_reg)
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = rd_ptr_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg + 1'b1;
                    if (CW'(rd_ptr_reg) == pos_reg)
                    begin
                        rd_active_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg - 1'b1;
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_PUT_KEY;
                end
            end

            S_PUT_KEY:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(pos_reg);
                mem_wr_data = key_reg;
                count_next  = count_reg + 1'b1;
                state_next  = S_DONE;
            end

            S_READ_WAIT:
            begin
                res_next.frame_value = mem_rd_data;
                state_next           = S_DONE;
            end

            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_active_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_active_reg <= rd_active_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        upper_reg     <= upper_next;
        matched_reg   <= matched_next;
        hi_moved_reg  <= hi_moved_next;
        cand_reg      <= cand_next;
        pos_reg       <= pos_next;
        rd_ptr_reg    <= rd_ptr_next;
        pend_addr_reg <= pend_addr_next;
        res_reg       <= res_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res             = res_reg;
        res.entry_count = sft_pkg::POS_W'(count_reg);
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count exceeds table depth");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en && mem_rd_addr == mem_wr_addr))
        else $error("read and write hit the same entry");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.status == sft_pkg::STATUS_FULL) |-> count_reg == DEPTH_C)
        else $error("full status with free entries");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_PUT_KEY) |=> count_reg == $past(count_reg))
        else $error("entry count changed outside insert or clear");
`endif

endmodule

>>> hdl/sorted_frame_table_core.sv
// Sorted frame table: top level with sequencer, frame store and output register.
// Every result passes through the output register before it reaches the outputs.
// Insert: search probes (about log2(count)+1), each a store read and a compare; unless full,
// entries at and above position move up one place and the key is written; query: two searches.
// Throughput: one item at a time; in_stall stays high until the result is taken.
// Reset clears the entry count and control; the frame store is not cleared.
`timescale 1ns / 1ps

module sorted_frame_table_core #(
    parameter int TABLE_DEPTH = sft_pkg::TABLE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [sft_pkg::FRAME_W-1:0]   frame_number,
    input  logic [sft_pkg::INDEX_W-1:0]   table_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sft_pkg::POS_W-1:0]     position,
    output logic                          frame_used,
    output logic                          next_valid,
    output logic [sft_pkg::FRAME_W-1:0]   next_frame,
    output logic [sft_pkg::FRAME_W-1:0]   frame_value,
    output logic [sft_pkg::STATUS_W-1:0]  status,
    output logic [sft_pkg::POS_W-1:0]     entry_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic                        res_valid;
    logic                        res_ack;
    sft_pkg::result_t            res;
    logic                        mem_rd_en;
    logic [AW-1:0]               mem_rd_addr;
    logic [sft_pkg::FRAME_W-1:0] mem_rd_data;
    logic                        mem_wr_en;
    logic [AW-1:0]               mem_wr_addr;
    logic [sft_pkg::FRAME_W-1:0] mem_wr_data;

    logic                        out_valid_reg;
    sft_pkg::result_t            out_reg;

    sft_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_action   (action),
        .in_frame    (frame_number),
        .in_index    (table_index),
        .res_valid   (res_valid),
        .res_ack     (res_ack),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    sft_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    assign res_ack = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ack)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = out_reg.position;
    assign frame_used  = out_reg.frame_used;
    assign next_valid  = out_reg.next_valid;
    assign next_frame  = out_reg.next_frame;
    assign frame_value = out_reg.frame_value;
    assign status      = out_reg.status;
    assign entry_count = out_reg.entry_count;

endmodule

>>> test/sorted_frame_table_core_test.sv
// Self-checking testbench for sorted_frame_table_core: directed rows, a fill and random items.
`timescale 1ns / 1ps

module sorted_frame_table_core_test;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int FILL_ITEMS   = 160;
    localparam int RANDOM_ITEMS = 380;
    localparam int SMALL_TABLE  = 64;
    localparam int SETTLE       = 50;

    typedef struct packed {
        sft_pkg::action_t                act;
        logic [sft_pkg::FRAME_W-1:0]     frame;
        logic [sft_pkg::INDEX_W-1:0]     index;
        logic                            typed;
        sft_pkg::result_t                res;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [1:0]                      action;
    logic [sft_pkg::FRAME_W-1:0]     frame_number;
    logic [sft_pkg::INDEX_W-1:0]     table_index;
    logic                            out_valid;
    logic                            out_stall;
    logic [sft_pkg::POS_W-1:0]       position;
    logic                            frame_used;
    logic                            next_valid;
    logic [sft_pkg::FRAME_W-1:0]     next_frame;
    logic [sft_pkg::FRAME_W-1:0]     frame_value;
    logic [sft_pkg::STATUS_W-1:0]    status;
    logic [sft_pkg::POS_W-1:0]       entry_count;

    logic                            jitter_on = 1'b1;
    logic                            hold_request = 1'b0;
    int unsigned                     cycle_count = 0;
    int                              mismatch_count = 0;

    logic [sft_pkg::FRAME_W-1:0]     shadow_frames [sft_pkg::TABLE_DEPTH];
    int unsigned                     shadow_count = 0;
    sft_pkg::result_t                pending_results [$];
    stim_row_t                       directed_rows [$];

    sorted_frame_table_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .frame_number (frame_number),
        .table_index  (table_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .position     (position),
        .frame_used   (frame_used),
        .next_valid   (next_valid),
        .next_frame   (next_frame),
        .frame_value  (frame_value),
        .status       (status),
        .entry_count  (entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // binary search that stops at the first probe equal to the number
    function automatic int unsigned probe_slot(input logic [sft_pkg::FRAME_W-1:0] num);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo  = 0;
        hi  = shadow_count;
        mid = hi / 2;
        while (lo < hi)
        begin
            if (shadow_frames[mid] == num)
                return mid;
            if (shadow_frames[mid] > num)
                hi = mid;
            else
                lo = mid + 1;
            mid = (lo + hi) / 2;
        end
        return mid;
    endfunction

    function automatic int unsigned first_above(input logic [sft_pkg::FRAME_W-1:0] num);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = shadow_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (shadow_frames[mid] > num)
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic sft_pkg::result_t predict_table_result(
        input sft_pkg::action_t            act,
        input logic [sft_pkg::FRAME_W-1:0] num,
        input logic [sft_pkg::INDEX_W-1:0] idx);
        sft_pkg::result_t r;
        int unsigned      slot;
        int unsigned      above;
        int unsigned      i;
        r = '0;
        case (act)
            sft_pkg::ACT_CLEAR:
                shadow_count = 0;
            sft_pkg::ACT_INSERT:
            begin
                slot = probe_slot(num);
                r.position = sft_pkg::POS_W'(slot);
                if (shadow_count >= sft_pkg::TABLE_DEPTH)
                    r.status = sft_pkg::STATUS_FULL;
                else
                begin
                    for (i = shadow_count; i > slot; i--)
                        shadow_frames[i] = shadow_frames[i - 1];
                    shadow_frames[slot] = num;
                    shadow_count++;
                end
            end
            sft_pkg::ACT_QUERY:
            begin
                slot = probe_slot(num);
                r.position = sft_pkg::POS_W'(slot);
                if (slot < shadow_count && shadow_frames[slot] == num)
                    r.frame_used = 1'b1;
                above = first_above(num);
                if (above < shadow_count)
                begin
                    r.next_valid = 1'b1;
                    r.next_frame = shadow_frames[above];
                end
            end
            default:
            begin
                if (idx < shadow_count)
                    r.frame_value = shadow_frames[idx];
                else
                    r.status = sft_pkg::STATUS_RANGE;
            end
        endcase
        r.entry_count = sft_pkg::POS_W'(shadow_count);
        return r;
    endfunction

    function automatic sft_pkg::result_t plain_result(
        input int unsigned                  pos,
        input logic [sft_pkg::STATUS_W-1:0] st,
        input int unsigned                  cnt);
        sft_pkg::result_t r;
        r             = '0;
        r.position    = sft_pkg::POS_W'(pos);
        r.status      = st;
        r.entry_count = sft_pkg::POS_W'(cnt);
        return r;
    endfunction

    // stored numbers and their neighbors, small numbers for duplicates, extremes and random numbers
    function automatic logic [sft_pkg::FRAME_W-1:0] pick_frame();
        int unsigned                 sel;
        logic [sft_pkg::FRAME_W-1:0] near;
        sel = $urandom_range(0, 99);
        if (shadow_count != 0 && sel < 40)
        begin
            near = shadow_frames[$urandom_range(0, shadow_count - 1)];
            return near + sft_pkg::FRAME_W'($urandom_range(0, 2)) - sft_pkg::FRAME_W'(1);
        end
        if (sel < 65)
            return sft_pkg::FRAME_W'($urandom_range(0, 63));
        if (sel < 75)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    task automatic add_row(input sft_pkg::action_t act,
                           input logic [sft_pkg::FRAME_W-1:0] num,
                           input logic [sft_pkg::INDEX_W-1:0] idx, input logic typed,
                           input sft_pkg::result_t res);
        stim_row_t row;
        row.act   = act;
        row.frame = num;
        row.index = idx;
        row.typed = typed;
        row.res   = res;
        directed_rows = {directed_rows, row};
    endtask

    task automatic send_item(input sft_pkg::action_t act,
                             input logic [sft_pkg::FRAME_W-1:0] num,
                             input logic [sft_pkg::INDEX_W-1:0] idx, input logic typed,
                             input sft_pkg::result_t typed_res);
        sft_pkg::result_t predicted;
        while (jitter_on && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        frame_number <= num;
        table_index  <= idx;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = predict_table_result(act, num, idx);
        pending_results = {pending_results, typed ? typed_res : predicted};
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic compare_field(input string label,
                                 input logic [sft_pkg::FRAME_W-1:0] want,
                                 input logic [sft_pkg::FRAME_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %0h, got %0h", label, want, got);
        end
    endtask

    task automatic check_result();
        sft_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: position %0d entry_count %0d",
                         position, entry_count);
        end
        else
        begin
            want = pending_results.pop_front();
            compare_field("position", sft_pkg::FRAME_W'(want.position),
                          sft_pkg::FRAME_W'(position));
            compare_field("frame_used", sft_pkg::FRAME_W'(want.frame_used),
                          sft_pkg::FRAME_W'(frame_used));
            compare_field("next_valid", sft_pkg::FRAME_W'(want.next_valid),
                          sft_pkg::FRAME_W'(next_valid));
            compare_field("next_frame", want.next_frame, next_frame);
            compare_field("frame_value", want.frame_value, frame_value);
            compare_field("status", sft_pkg::FRAME_W'(want.status),
                          sft_pkg::FRAME_W'(status));
            compare_field("entry_count", sft_pkg::FRAME_W'(want.entry_count),
                          sft_pkg::FRAME_W'(entry_count));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            check_result();
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request <= 1'b0;
                out_stall    <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= jitter_on && ($urandom_range(0, 99) < 27);
        end
    end

    initial
    begin
        sft_pkg::action_t            act;
        logic [sft_pkg::FRAME_W-1:0] num;
        logic [sft_pkg::INDEX_W-1:0] idx;
        int unsigned                 sel;
        int                          n;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = sft_pkg::ACT_CLEAR;
        frame_number = '0;
        table_index  = '0;

        add_row(sft_pkg::ACT_READ,   32'd0,         10'd0,    1'b1,
                plain_result(0, sft_pkg::STATUS_RANGE, 0));
        add_row(sft_pkg::ACT_QUERY,  32'd0,         10'd0,    1'b1,
                plain_result(0, sft_pkg::STATUS_OK, 0));
        add_row(sft_pkg::ACT_INSERT, 32'hFFFF_FFFF, 10'd0,    1'b1,
                plain_result(0, sft_pkg::STATUS_OK, 1));
        add_row(sft_pkg::ACT_INSERT, 32'd0,         10'd0,    1'b1,
                plain_result(0, sft_pkg::STATUS_OK, 2));
        add_row(sft_pkg::ACT_INSERT, 32'd1000,      10'd0,    1'b0, '0);
        add_row(sft_pkg::ACT_INSERT, 32'd1000,      10'd0,    1'b0, '0);
        add_row(sft_pkg::ACT_INSERT, 32'd1000,      10'd0,    1'b0, '0);
        add_row(sft_pkg::ACT_INSERT, 32'd500,       10'd0,    1'b0, '0);
        add_row(sft_pkg::ACT_QUERY,  32'd1000,      10'd0,    1'b0, '0);
        add_row(sft_pkg::ACT_QUERY,  32'd999,       10'd0,    1'b0, '0);
        add_row(sft_pkg::ACT_QUERY,  32'hFFFF_FFFF, 10'd0,    1'b0, '0);
        add_row(sft_pkg::ACT_QUERY,  32'd0,         10'd0,    1'b0, '0);
        add_row(sft_pkg::ACT_QUERY,  32'hFFFF_FFFE, 10'd0,    1'b0, '0);
        add_row(sft_pkg::ACT_READ,   32'd0,         10'd0,    1'b0, '0);
        add_row(sft_pkg::ACT_READ,   32'd0,         10'd5,    1'b0, '0);
        add_row(sft_pkg::ACT_READ,   32'd0,         10'd6,    1'b1,
                plain_result(0, sft_pkg::STATUS_RANGE, 6));
        add_row(sft_pkg::ACT_READ,   32'd0,         10'd1023, 1'b1,
                plain_result(0, sft_pkg::STATUS_RANGE, 6));
        add_row(sft_pkg::ACT_CLEAR,  32'd0,         10'd0,    1'b1,
                plain_result(0, sft_pkg::STATUS_OK, 0));
        add_row(sft_pkg::ACT_QUERY,  32'd1000,      10'd0,    1'b1,
                plain_result(0, sft_pkg::STATUS_OK, 0));
        add_row(sft_pkg::ACT_READ,   32'd0,         10'd0,    1'b1,
                plain_result(0, sft_pkg::STATUS_RANGE, 0));
        add_row(sft_pkg::ACT_INSERT, 32'h8000_0000, 10'd0,    1'b1,
                plain_result(0, sft_pkg::STATUS_OK, 1));
        add_row(sft_pkg::ACT_INSERT, 32'h7FFF_FFFF, 10'd0,    1'b0, '0);
        add_row(sft_pkg::ACT_QUERY,  32'h8000_0000, 10'd0,    1'b0, '0);
        add_row(sft_pkg::ACT_CLEAR,  32'd0,         10'd0,    1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].act, directed_rows[i].frame, directed_rows[i].index,
                      directed_rows[i].typed, directed_rows[i].res);
        wait_drained();

        // grow the table in ascending order so that inserts stay cheap
        num = $urandom_range(0, 15);
        repeat (FILL_ITEMS)
        begin
            num = num + sft_pkg::FRAME_W'($urandom_range(0, 3));
            send_item(sft_pkg::ACT_INSERT, num, sft_pkg::INDEX_W'($urandom()), 1'b0, '0);
        end
        send_item(sft_pkg::ACT_INSERT, '0, '0, 1'b0, '0);
        send_item(sft_pkg::ACT_INSERT, '1, '1, 1'b0, '0);
        send_item(sft_pkg::ACT_INSERT, $urandom(), '0, 1'b0, '0);
        send_item(sft_pkg::ACT_QUERY, shadow_frames[$urandom_range(0, shadow_count - 1)], '0,
                  1'b0, '0);
        send_item(sft_pkg::ACT_QUERY, '1, '0, 1'b0, '0);
        send_item(sft_pkg::ACT_READ, $urandom(), 10'd1023, 1'b0, '0);
        send_item(sft_pkg::ACT_READ, $urandom(), 10'd0, 1'b0, '0);
        send_item(sft_pkg::ACT_CLEAR, $urandom(), '0, 1'b0, '0);
        wait_drained();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 100)
                jitter_on <= 1'b0;
            if (n == 200)
                jitter_on <= 1'b1;
            if (n == 300)
                hold_request <= 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 4)
                act = sft_pkg::ACT_CLEAR;
            else if (sel < 45)
                act = (shadow_count >= SMALL_TABLE) ? sft_pkg::ACT_CLEAR : sft_pkg::ACT_INSERT;
            else if (sel < 75)
                act = sft_pkg::ACT_QUERY;
            else
                act = sft_pkg::ACT_READ;
            if ($urandom_range(0, 99) < 85)
                idx = sft_pkg::INDEX_W'($urandom_range(0, shadow_count + 1));
            else
                idx = sft_pkg::INDEX_W'($urandom_range(0, sft_pkg::TABLE_DEPTH - 1));
            num = pick_frame();
            send_item(act, num, idx, 1'b0, '0);
        end
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
hdl/sft_pkg.sv
hdl/sft_mem.sv
hdl/sft_ctrl.sv
hdl/sorted_frame_table_core.sv
test/sorted_frame_table_core_test.sv
